// ===== rtl/core/lkc_pkg.sv =====
// ----------------------------------------------------------------------------
// lkc_pkg
// Shared types and constants for the LFU key cache: field widths, command
// codes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package lkc_pkg;

  localparam int KEY_W = 32;
  localparam int CNT_W = 16;

  localparam logic CMD_PRELOAD = 1'b0;
  localparam logic CMD_ACCESS  = 1'b1;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } lkc_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;    // latch the request, restart the scan
    logic scan;    // read one slot, advance the address
    logic commit;  // write back the chosen slot, load the result register
  } lkc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_last;  // address points at the last slot
    logic out_free;   // result register can take a new result
  } lkc_stat_t;

endpackage

// ===== rtl/core/lkc_if.sv =====
// ----------------------------------------------------------------------------
// lkc_in_if / lkc_out_if
// Valid/ready channels carrying requests into and results out of the cache.
// ----------------------------------------------------------------------------
interface lkc_in_if import lkc_pkg::*;;
  logic             valid;
  logic             ready;
  logic             command;
  logic [KEY_W-1:0] key;
  logic [CNT_W-1:0] preload_count;

  modport source (output valid, command, key, preload_count, input ready);
  modport sink   (input valid, command, key, preload_count, output ready);
endinterface

interface lkc_out_if import lkc_pkg::*;;
  logic             valid;
  logic             ready;
  logic             hit;
  logic [CNT_W-1:0] count_after;
  logic             rejected;
  logic             evicted;
  logic [KEY_W-1:0] evicted_key;
  logic [CNT_W-1:0] evicted_count;

  modport source (output valid, hit, count_after, rejected, evicted, evicted_key,
                  evicted_count, input ready);
  modport sink   (input valid, hit, count_after, rejected, evicted, evicted_key,
                  evicted_count, output ready);
endinterface

// ===== rtl/core/lfu_key_cache_top.sv =====
// ----------------------------------------------------------------------------
// lfu_key_cache_top
// Least-frequently-used key table with hit counting and eviction.
// ----------------------------------------------------------------------------
// A table of up to ENTRIES four-character keys, each with a 16-bit use
// count. A preload request writes a key with a given count into the lowest
// free slot (or overwrites the count of a key already present) and is
// rejected when the table is full. An access request that hits bumps the
// count, saturating at 65535; a miss inserts the key with count 1, first
// evicting the slot with the lowest count (smallest key on a tie) when the
// table is full. Every request yields exactly one result. Requests are
// handled one at a time: each one scans every slot through a single read
// port, one slot per cycle, then drains the read stage and commits the
// result; the next request can be taken only after that commit. The result
// sits in an output register, so the next request is accepted while it
// waits. Slot valid bits clear on reset; no clearing pass is needed.
module lfu_key_cache_top import lkc_pkg::*; #(
  parameter int ENTRIES = 10
) (
  input logic        clk,
  input logic        rst_n,
  lkc_in_if.sink     in_ch,
  lkc_out_if.source  out_ch
);

  lkc_cmd_t  cmd;
  lkc_stat_t stat;

  // sequencer: accept, scan, drain, commit
  lkc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // slot storage, scan trackers and result register
  lkc_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_command        (in_ch.command),
    .in_key            (in_ch.key),
    .in_preload_count  (in_ch.preload_count),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_hit           (out_ch.hit),
    .out_count_after   (out_ch.count_after),
    .out_rejected      (out_ch.rejected),
    .out_evicted       (out_ch.evicted),
    .out_evicted_key   (out_ch.evicted_key),
    .out_evicted_count (out_ch.evicted_count)
  );

endmodule

// ===== rtl/core/lkc_ctrl.sv =====
// ----------------------------------------------------------------------------
// lkc_ctrl
// Sequencer for one request: accept, scan all slots, drain the read
// pipeline, then commit once the result register is free.
// ----------------------------------------------------------------------------
module lkc_ctrl import lkc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  lkc_stat_t stat,
  output lkc_cmd_t  cmd
);

  lkc_state_t state_r;
  lkc_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat.scan_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.scan   = 1'b0;
    cmd.commit = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      ST_DRAIN: begin
      end
      ST_COMMIT: begin
        cmd.commit = stat.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/core/lkc_dp.sv =====
// ----------------------------------------------------------------------------
// lkc_dp
// Slot storage, scan trackers (match, first free slot, eviction victim),
// write-back decision and the result register.
// ----------------------------------------------------------------------------
module lkc_dp import lkc_pkg::*; #(
  parameter int ENTRIES = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  lkc_cmd_t         cmd,
  output lkc_stat_t        stat,
  input  logic             in_command,
  input  logic [KEY_W-1:0] in_key,
  input  logic [CNT_W-1:0] in_preload_count,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_hit,
  output logic [CNT_W-1:0] out_count_after,
  output logic             out_rejected,
  output logic             out_evicted,
  output logic [KEY_W-1:0] out_evicted_key,
  output logic [CNT_W-1:0] out_evicted_count
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(ENTRIES - 1);

  // slot storage
  logic [KEY_W-1:0]   key_mem [ENTRIES];
  logic [CNT_W-1:0]   cnt_mem [ENTRIES];
  logic [ENTRIES-1:0] slot_vld_r;

  // latched request
  logic             cmd_r;
  logic [KEY_W-1:0] key_r;
  logic [CNT_W-1:0] pc_r;

  // scan address and read stage
  logic [AW-1:0]    addr_r;
  logic             rd_vld_r;
  logic [AW-1:0]    rd_idx_r;
  logic             rd_slot_vld_r;
  logic [KEY_W-1:0] rd_key_r;
  logic [CNT_W-1:0] rd_cnt_r;

  // trackers
  logic             match_r;
  logic [AW-1:0]    match_idx_r;
  logic [CNT_W-1:0] match_cnt_r;
  logic             free_found_r;
  logic [AW-1:0]    free_idx_r;
  logic             best_found_r;
  logic [AW-1:0]    best_idx_r;
  logic [KEY_W-1:0] best_key_r;
  logic [CNT_W-1:0] best_cnt_r;

  // result register
  logic             out_valid_r;
  logic             out_hit_r;
  logic [CNT_W-1:0] out_cnt_r;
  logic             out_rej_r;
  logic             out_ev_r;
  logic [KEY_W-1:0] out_evk_r;
  logic [CNT_W-1:0] out_evc_r;

  // commit decision
  logic             wr_en;
  logic [AW-1:0]    wr_idx;
  logic [CNT_W-1:0] wr_cnt;
  logic             res_hit;
  logic [CNT_W-1:0] res_cnt;
  logic             res_rej;
  logic             res_ev;
  logic [KEY_W-1:0] res_evk;
  logic [CNT_W-1:0] res_evc;

  logic cand_match;
  logic cand_better;

  assign stat.scan_last = (addr_r == LAST_IDX);
  assign stat.out_free  = !out_valid_r || out_ready;

  // latch request on acceptance
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= in_command;
      key_r <= in_key;
      pc_r  <= in_preload_count;
    end
  end

  // scan address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= '0;
    end else if (cmd.load) begin
      addr_r <= '0;
    end else if (cmd.scan && !stat.scan_last) begin
      addr_r <= addr_r + AW'(1);
    end
  end

  // read stage: one slot per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.scan;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      rd_key_r      <= key_mem[addr_r];
      rd_cnt_r      <= cnt_mem[addr_r];
      rd_slot_vld_r <= slot_vld_r[addr_r];
      rd_idx_r      <= addr_r;
    end
  end

  assign cand_match  = rd_slot_vld_r && (rd_key_r == key_r);
  assign cand_better = !best_found_r || (rd_cnt_r < best_cnt_r) ||
                       ((rd_cnt_r == best_cnt_r) && (rd_key_r < best_key_r));

  // tracker flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r      <= 1'b0;
      free_found_r <= 1'b0;
      best_found_r <= 1'b0;
    end else if (cmd.load) begin
      match_r      <= 1'b0;
      free_found_r <= 1'b0;
      best_found_r <= 1'b0;
    end else if (rd_vld_r) begin
      if (cand_match) match_r <= 1'b1;
      if (!rd_slot_vld_r) free_found_r <= 1'b1;
      if (rd_slot_vld_r) best_found_r <= 1'b1;
    end
  end

  // tracker payload
  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      if (cand_match && !match_r) begin
        match_idx_r <= rd_idx_r;
        match_cnt_r <= rd_cnt_r;
      end
      if (!rd_slot_vld_r && !free_found_r) begin
        free_idx_r <= rd_idx_r;
      end
      if (rd_slot_vld_r && cand_better) begin
        best_idx_r <= rd_idx_r;
        best_key_r <= rd_key_r;
        best_cnt_r <= rd_cnt_r;
      end
    end
  end

  // decide the write-back and the result
  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = match_idx_r;
    wr_cnt  = pc_r;
    res_hit = 1'b0;
    res_rej = 1'b0;
    res_ev  = 1'b0;
    res_evk = '0;
    res_evc = '0;
    if (match_r) begin
      res_hit = 1'b1;
      wr_en   = 1'b1;
      if (cmd_r == CMD_ACCESS) begin
        wr_cnt = (match_cnt_r == CNT_MAX) ? CNT_MAX : match_cnt_r + CNT_ONE;
      end
    end else if (cmd_r == CMD_PRELOAD) begin
      if (free_found_r) begin
        wr_en  = 1'b1;
        wr_idx = free_idx_r;
      end else begin
        res_rej = 1'b1;
      end
    end else begin
      wr_en  = 1'b1;
      wr_cnt = CNT_ONE;
      if (free_found_r) begin
        wr_idx = free_idx_r;
      end else begin
        // table full: replace the least used slot
        wr_idx  = best_idx_r;
        res_ev  = 1'b1;
        res_evk = best_key_r;
        res_evc = best_cnt_r;
      end
    end
    res_cnt = res_rej ? '0 : wr_cnt;
  end

  // slot write-back
  always_ff @(posedge clk) begin
    if (cmd.commit && wr_en) begin
      key_mem[wr_idx] <= key_r;
      cnt_mem[wr_idx] <= wr_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_vld_r <= '0;
    end else if (cmd.commit && wr_en) begin
      slot_vld_r[wr_idx] <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_hit_r <= res_hit;
      out_cnt_r <= res_cnt;
      out_rej_r <= res_rej;
      out_ev_r  <= res_ev;
      out_evk_r <= res_evk;
      out_evc_r <= res_evc;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_count_after   = out_cnt_r;
  assign out_rejected      = out_rej_r;
  assign out_evicted       = out_ev_r;
  assign out_evicted_key   = out_evk_r;
  assign out_evicted_count = out_evc_r;

`ifndef ASSERT_OFF
  a_drained_at_commit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !rd_vld_r && !cmd.scan)
    else $error("commit while slot reads are still in flight");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !out_valid_r || out_ready)
    else $error("result register overwritten before it was taken");

  a_full_when_no_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && !match_r && !free_found_r |-> &slot_vld_r)
    else $error("scan found no free slot but the table is not full");

  a_evict_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ev_r |-> &slot_vld_r)
    else $error("eviction reported with free slots left");
`endif

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: LFU key cache testbench
// Drives preload and access requests into lfu_key_cache_top and checks each
// result against a cycle-free table model kept in the bench. A short table
// of directed requests covers key and count extremes, saturation, preload
// of a present key, rejection and eviction ties. Random requests follow,
// drawn mostly from a small pool of string keys so that hits, evictions and
// rejections keep coming, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb import lkc_pkg::*;;

  localparam int SLOTS    = 10;
  localparam int RAND_REQ = 600;
  localparam int POOL_SZ  = 14;
  localparam int SHOW_MAX = 10;

  // One result as the cache reports it.
  typedef struct packed {
    logic             hit;
    logic [CNT_W-1:0] count_after;
    logic             rejected;
    logic             evicted;
    logic [KEY_W-1:0] evicted_key;
    logic [CNT_W-1:0] evicted_count;
  } cache_result_t;

  // One directed request; the result is typed in only where fixed is set.
  typedef struct packed {
    logic             command;
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] preload_count;
    logic             fixed;
    cache_result_t    result;
  } directed_row_t;

  localparam cache_result_t NONE = '0;

  // Keys used below: 'A' = 41000000, 'AB' = 41420000, 'zz' = 7A7A0000 etc.
  localparam int DIR_ROWS = 24;
  localparam directed_row_t DIRECTED [DIR_ROWS] = '{
    // empty table: key zero with count zero, then the all-ones extremes
    '{CMD_PRELOAD, 32'h0000_0000, 16'h0000, 1'b1, '{1'b0, 16'h0000, 1'b0, 1'b0, 32'h0, 16'h0}},
    '{CMD_PRELOAD, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, '{1'b0, 16'hFFFF, 1'b0, 1'b0, 32'h0, 16'h0}},
    // hit at the top count stays saturated
    '{CMD_ACCESS,  32'hFFFF_FFFF, 16'h1234, 1'b1, '{1'b1, 16'hFFFF, 1'b0, 1'b0, 32'h0, 16'h0}},
    '{CMD_ACCESS,  32'h0000_0000, 16'h0000, 1'b1, '{1'b1, 16'h0001, 1'b0, 1'b0, 32'h0, 16'h0}},
    // preload of a present key overwrites its count
    '{CMD_PRELOAD, 32'h0000_0000, 16'h0005, 1'b1, '{1'b1, 16'h0005, 1'b0, 1'b0, 32'h0, 16'h0}},
    '{CMD_ACCESS,  32'h4100_0000, 16'hFFFF, 1'b1, '{1'b0, 16'h0001, 1'b0, 1'b0, 32'h0, 16'h0}},
    // fill the rest of the table
    '{CMD_ACCESS,  32'h4142_0000, 16'h0000, 1'b0, NONE},
    '{CMD_ACCESS,  32'h4142_4300, 16'h0000, 1'b0, NONE},
    '{CMD_ACCESS,  32'h4142_4344, 16'h0000, 1'b0, NONE},
    '{CMD_ACCESS,  32'h4200_0000, 16'h0000, 1'b0, NONE},
    '{CMD_ACCESS,  32'h5A00_0000, 16'h0000, 1'b0, NONE},
    '{CMD_PRELOAD, 32'h7A7A_0000, 16'h0003, 1'b0, NONE},
    '{CMD_PRELOAD, 32'h7100_0000, 16'h0002, 1'b0, NONE},
    // full table: a new preload bounces
    '{CMD_PRELOAD, 32'h1234_5678, 16'h0009, 1'b1, '{1'b0, 16'h0000, 1'b1, 1'b0, 32'h0, 16'h0}},
    // misses evict the lowest count, smallest key on a tie
    '{CMD_ACCESS,  32'h0A0B_0C0D, 16'h0000, 1'b0, NONE},
    '{CMD_ACCESS,  32'h0A0B_0C0D, 16'h0000, 1'b0, NONE},
    '{CMD_ACCESS,  32'h0000_0001, 16'h0000, 1'b0, NONE},
    '{CMD_PRELOAD, 32'hFFFF_FFFF, 16'h0000, 1'b1, '{1'b1, 16'h0000, 1'b0, 1'b0, 32'h0, 16'h0}},
    '{CMD_ACCESS,  32'h7F7F_7F7F, 16'h0000, 1'b0, NONE},
    '{CMD_PRELOAD, 32'h0000_0000, 16'hFFFF, 1'b1, '{1'b1, 16'hFFFF, 1'b0, 1'b0, 32'h0, 16'h0}},
    '{CMD_ACCESS,  32'h0000_0000, 16'h0000, 1'b1, '{1'b1, 16'hFFFF, 1'b0, 1'b0, 32'h0, 16'h0}},
    '{CMD_ACCESS,  32'h0A0B_0C0D, 16'h0000, 1'b0, NONE},
    '{CMD_PRELOAD, 32'h8000_0000, 16'hFFFE, 1'b1, '{1'b0, 16'h0000, 1'b1, 1'b0, 32'h0, 16'h0}},
    '{CMD_ACCESS,  32'h8000_0000, 16'h0000, 1'b0, NONE}
  };

  logic clk;
  logic rst_n;

  lkc_in_if  in_ch ();
  lkc_out_if out_ch ();

  lfu_key_cache_top #(.ENTRIES(SLOTS)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Bench copy of the key table.
  logic             tbl_valid [SLOTS];
  logic [KEY_W-1:0] tbl_key   [SLOTS];
  logic [CNT_W-1:0] tbl_count [SLOTS];

  cache_result_t    pending_results [$];
  int               mismatch_count = 0;
  logic [KEY_W-1:0] key_pool [POOL_SZ];

  // Idling switches, flipped per phase of the random part.
  bit send_idle = 1'b0;
  bit recv_idle = 1'b0;
  int stall_left = 0;

  // 10 ns clock.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Hard stop, far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_length();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // Build a string key of 0..4 nonzero chars, first char in the top byte.
  function automatic logic [KEY_W-1:0] string_key();
    logic [KEY_W-1:0] k;
    int len;
    k   = '0;
    len = $urandom_range(0, 4);
    for (int i = 0; i < len; i++) k[KEY_W-1-8*i -: 8] = 8'($urandom_range(1, 255));
    return k;
  endfunction

  // Apply one request to the bench table and return the result it yields.
  function automatic cache_result_t apply_request(logic cmd, logic [KEY_W-1:0] k,
                                                  logic [CNT_W-1:0] pc);
    cache_result_t r;
    int match, free, victim;
    r      = '0;
    match  = -1;
    free   = -1;
    victim = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (tbl_valid[i] && tbl_key[i] == k && match < 0) match = i;
      if (!tbl_valid[i] && free < 0) free = i;
      // lowest count wins, smallest key on a tie
      if (tbl_valid[i] && (victim < 0 || tbl_count[i] < tbl_count[victim] ||
          (tbl_count[i] == tbl_count[victim] && tbl_key[i] < tbl_key[victim])))
        victim = i;
    end
    if (cmd == CMD_PRELOAD) begin
      if (match >= 0) begin
        tbl_count[match] = pc;
        r.hit            = 1'b1;
        r.count_after    = pc;
      end else if (free >= 0) begin
        tbl_valid[free] = 1'b1;
        tbl_key[free]   = k;
        tbl_count[free] = pc;
        r.count_after   = pc;
      end else begin
        r.rejected = 1'b1;
      end
    end else if (match >= 0) begin
      if (tbl_count[match] != CNT_MAX) tbl_count[match] = tbl_count[match] + CNT_ONE;
      r.hit         = 1'b1;
      r.count_after = tbl_count[match];
    end else begin
      if (free < 0) begin
        free            = victim;
        r.evicted       = 1'b1;
        r.evicted_key   = tbl_key[victim];
        r.evicted_count = tbl_count[victim];
      end
      tbl_valid[free] = 1'b1;
      tbl_key[free]   = k;
      tbl_count[free] = CNT_ONE;
      r.count_after   = CNT_ONE;
    end
    return r;
  endfunction

  task automatic note_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= SHOW_MAX) $display("%0t ns: %s", $realtime, what);
  endtask

  // Raise a request, hold it until taken, then queue its expected result.
  // A fixed result from the directed table overrides the bench table, which
  // still advances so later rows stay in step.
  task automatic send_request(input logic cmd, input logic [KEY_W-1:0] k,
                              input logic [CNT_W-1:0] pc, input logic fixed,
                              input cache_result_t fixed_result);
    cache_result_t predicted;
    in_ch.valid         <= 1'b1;
    in_ch.command       <= cmd;
    in_ch.key           <= k;
    in_ch.preload_count <= pc;
    do @(posedge clk); while (!in_ch.ready);
    predicted = apply_request(cmd, k, pc);
    pending_results.push_back(fixed ? fixed_result : predicted);
  endtask

  // On about half the calls while sender idling is on, drop valid for a random gap. Valid stays high
  // otherwise so the next request goes out back to back.
  task automatic sender_gap();
    if (send_idle && $urandom_range(0, 1) == 1) begin
      in_ch.valid <= 1'b0;
      repeat (gap_length()) @(posedge clk);
    end
  endtask

  // Hold off the sender until every queued result has come back.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Result side: stall ready in random stretches while receiver idling is on.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (recv_idle && $urandom_range(0, 3) == 0) begin
      stall_left   <= gap_length() - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Check every accepted result against the oldest expectation.
  always @(posedge clk) begin
    cache_result_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.hit, out_ch.count_after, out_ch.rejected, out_ch.evicted,
              out_ch.evicted_key, out_ch.evicted_count};
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("unexpected result hit=%0b cnt=%h rej=%0b ev=%0b key=%h evc=%h",
                                got.hit, got.count_after, got.rejected, got.evicted,
                                got.evicted_key, got.evicted_count));
      end else begin
        want = pending_results.pop_front();
        if (got.hit !== want.hit || got.count_after !== want.count_after ||
            got.rejected !== want.rejected || got.evicted !== want.evicted ||
            got.evicted_key !== want.evicted_key ||
            got.evicted_count !== want.evicted_count)
          note_mismatch($sformatf({"result mismatch: exp hit=%0b cnt=%h rej=%0b ev=%0b ",
                                   "key=%h evc=%h, got hit=%0b cnt=%h rej=%0b ev=%0b ",
                                   "key=%h evc=%h"},
                                  want.hit, want.count_after, want.rejected, want.evicted,
                                  want.evicted_key, want.evicted_count,
                                  got.hit, got.count_after, got.rejected, got.evicted,
                                  got.evicted_key, got.evicted_count));
      end
    end
  end

  initial begin
    logic             cmd;
    logic [KEY_W-1:0] k;
    logic [CNT_W-1:0] pc;
    int               pick;

    // Drive every input to a known value before the first edge.
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.command       = CMD_PRELOAD;
    in_ch.key           = '0;
    in_ch.preload_count = '0;
    out_ch.ready        = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_key[i]   = '0;
      tbl_count[i] = '0;
    end
    for (int i = 0; i < POOL_SZ; i++) key_pool[i] = string_key();

    // Hold reset, then release it once.
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table, light idling on both sides.
    send_idle = 1'b1;
    recv_idle = 1'b1;
    foreach (DIRECTED[i]) begin
      send_request(DIRECTED[i].command, DIRECTED[i].key, DIRECTED[i].preload_count,
                   DIRECTED[i].fixed, DIRECTED[i].result);
      sender_gap();
    end
    // Let the pipeline empty out before random traffic starts.
    drain_results();

    for (int n = 0; n < RAND_REQ; n++) begin
      // Pick a new idling mix every 60 requests, idle-free phases included.
      if (n % 60 == 0) begin
        pick      = $urandom_range(0, 3);
        send_idle = pick[0];
        recv_idle = pick[1];
      end

      // Keys mostly from the pool so hits and evictions recur; refresh a
      // pool entry now and then, and throw in raw 32-bit noise.
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        k = $urandom();
      end else if (pick < 14) begin
        pick           = $urandom_range(0, POOL_SZ - 1);
        key_pool[pick] = string_key();
        k              = key_pool[pick];
      end else begin
        k = key_pool[$urandom_range(0, POOL_SZ - 1)];
      end

      // Favor small counts for eviction ties and the top end for saturation.
      pick = $urandom_range(0, 99);
      if (pick < 30)      pc = CNT_W'($urandom_range(0, 3));
      else if (pick < 45) pc = CNT_MAX;
      else if (pick < 55) pc = CNT_MAX - CNT_ONE;
      else                pc = CNT_W'($urandom());

      cmd = ($urandom_range(0, 9) < 7) ? CMD_ACCESS : CMD_PRELOAD;
      send_request(cmd, k, pc, 1'b0, NONE);

      // Occasionally hold the sender until the cache has gone quiet.
      if ($urandom_range(0, 39) == 0) drain_results();
      else sender_gap();
    end

    // Wait for the last results, then give the cache time to show strays.
    drain_results();
    repeat (SLOTS + 5) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/lkc_pkg.sv
rtl/core/lkc_if.sv
rtl/core/lkc_ctrl.sv
rtl/core/lkc_dp.sv
rtl/core/lfu_key_cache_top.sv
dv/tb.sv
